>>> sv/bcra_pkg.sv
// shared types, constants and the byte scan function for the bitmap run allocator
// no dependencies; used by every other file through scoped names
package bcra_pkg;

  localparam int MAP_BYTES = 64;
  localparam int ADDR_W    = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam int CFG_W     = 7;
  localparam int IDX_W     = 9;
  localparam int LEN_W     = 10;

  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  typedef enum logic [1:0] {
    REQ_SCAN  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_TEST  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_kind_t;

  typedef struct packed {
    req_kind_t        req_type;
    logic [IDX_W-1:0] bit_addr;
    logic             bit_value;
    logic [LEN_W-1:0] run_length;
  } req_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] run_start;
    logic             bit_state;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WR_RD,
    ST_WR_MOD,
    ST_TS_RD,
    ST_TS_CAP,
    ST_CLEAR,
    ST_SCAN_INIT,
    ST_SCAN,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic rd_req;
    logic wr_bit;
    logic test_cap;
    logic clr_all;
    logic scan_init;
    logic scan_step;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic len_bad;
    logic hit;
    logic exhausted;
  } status_t;

  typedef struct packed {
    logic [LEN_W-1:0] count;
    logic             hit;
    logic [2:0]       pos;
  } byte_scan_t;

  // walk one byte lsb first, counting free bits until the run length is reached
  function automatic byte_scan_t scan_byte(input logic [7:0] data,
                                           input logic [LEN_W-1:0] count_in,
                                           input logic [LEN_W-1:0] len);
    byte_scan_t r;
    r.count = count_in;
    r.hit   = 1'b0;
    r.pos   = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (!r.hit) begin
        if (data[i]) begin
          r.count = '0;
        end else begin
          r.count = r.count + 1'b1;
          if (r.count == len) begin
            r.hit = 1'b1;
            r.pos = 3'(i);
          end
        end
      end
    end
    return r;
  endfunction

endpackage

>>> sv/bitmap_contiguous_run_allocator_unit.sv
// top level of the bitmap run allocator: sequencer, datapath and result register
// depends on bcra_pkg, bcra_ctrl and bcra_dp
//
//   channel   signals                         direction  moves
//   in        in_valid, in_stall, in_data     into       request (scan, write, test, clear)
//   out       out_valid, out_stall, out_data  out of     one result per request
//   cfg       cfg_valid, cfg_ready, cfg_data  into       bytes_in_use write
//
// one request at a time; a new request is taken while the last result waits in the output register
// write and test: a registered memory read, then the bit modify (write) or the bit capture (test)
// clear all: one clear step; scan: reads the bytes in use (at most 64), one bitmap byte
// per cycle through the single memory read port, and stops early when a run is found or cannot fit
// synchronous reset frees every bit at once through per-byte valid flags; no clearing pass
// out_stall holds the result register; in_stall is high whenever a request is in progress
module bitmap_contiguous_run_allocator_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  bcra_pkg::req_t                in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output bcra_pkg::res_t                out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bcra_pkg::CFG_W-1:0]    cfg_data
);

  bcra_pkg::cmd_t    cmd;
  bcra_pkg::status_t status;
  bcra_pkg::res_t    res;
  logic              busy;
  logic              out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy;
  assign out_free  = !out_valid || !out_stall;

  bcra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .req_type (in_data.req_type),
    .status   (status),
    .out_free (out_free),
    .cmd      (cmd),
    .busy     (busy)
  );

  bcra_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .status   (status),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_data <= res;
    end
  end

endmodule

>>> sv/bcra_ctrl.sv
// request sequencer for the bitmap run allocator
// depends on bcra_pkg; drives datapath commands from datapath status
module bcra_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  bcra_pkg::req_kind_t req_type,
  input  bcra_pkg::status_t   status,
  input  logic                out_free,
  output bcra_pkg::cmd_t      cmd,
  output logic                busy
);

  bcra_pkg::ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bcra_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bcra_pkg::ST_IDLE: begin
        if (in_valid) begin
          unique case (req_type)
            bcra_pkg::REQ_SCAN:  state_next = bcra_pkg::ST_SCAN_INIT;
            bcra_pkg::REQ_WRITE: state_next = bcra_pkg::ST_WR_RD;
            bcra_pkg::REQ_TEST:  state_next = bcra_pkg::ST_TS_RD;
            bcra_pkg::REQ_CLEAR: state_next = bcra_pkg::ST_CLEAR;
            default:             state_next = bcra_pkg::ST_IDLE;
          endcase
        end
      end
      bcra_pkg::ST_WR_RD:  state_next = bcra_pkg::ST_WR_MOD;
      bcra_pkg::ST_WR_MOD: state_next = bcra_pkg::ST_DONE;
      bcra_pkg::ST_TS_RD:  state_next = bcra_pkg::ST_TS_CAP;
      bcra_pkg::ST_TS_CAP: state_next = bcra_pkg::ST_DONE;
      bcra_pkg::ST_CLEAR:  state_next = bcra_pkg::ST_DONE;
      bcra_pkg::ST_SCAN_INIT: begin
        state_next = status.len_bad ? bcra_pkg::ST_DONE : bcra_pkg::ST_SCAN;
      end
      bcra_pkg::ST_SCAN: begin
        if (status.hit || status.exhausted) begin
          state_next = bcra_pkg::ST_DONE;
        end
      end
      bcra_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = bcra_pkg::ST_IDLE;
        end
      end
      default: state_next = bcra_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state != bcra_pkg::ST_IDLE);
    unique case (state)
      bcra_pkg::ST_IDLE:      cmd.load      = in_valid;
      bcra_pkg::ST_WR_RD:     cmd.rd_req    = 1'b1;
      bcra_pkg::ST_WR_MOD:    cmd.wr_bit    = 1'b1;
      bcra_pkg::ST_TS_RD:     cmd.rd_req    = 1'b1;
      bcra_pkg::ST_TS_CAP:    cmd.test_cap  = 1'b1;
      bcra_pkg::ST_CLEAR:     cmd.clr_all   = 1'b1;
      bcra_pkg::ST_SCAN_INIT: cmd.scan_init = 1'b1;
      bcra_pkg::ST_SCAN:      cmd.scan_step = 1'b1;
      bcra_pkg::ST_DONE:      cmd.push      = out_free;
      default:                cmd           = '0;
    endcase
  end

endmodule

>>> sv/bcra_dp.sv
// datapath of the bitmap run allocator: bitmap memory, valid bits, scan counter, result
// depends on bcra_pkg; steered by bcra_ctrl commands
module bcra_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  bcra_pkg::req_t                in_data,
  input  logic                          cfg_we,
  input  logic [bcra_pkg::CFG_W-1:0]    cfg_data,
  input  bcra_pkg::cmd_t                cmd,
  output bcra_pkg::status_t             status,
  output bcra_pkg::res_t                res
);

  logic [bcra_pkg::CFG_W-1:0]     bytes_in_use;
  bcra_pkg::req_t                 req;
  logic [7:0]                     mem [bcra_pkg::MAP_BYTES];
  logic [bcra_pkg::MAP_BYTES-1:0] vld;
  logic [7:0]                     rd_data;
  logic                           rd_vld;
  logic [bcra_pkg::CFG_W-1:0]     ptr;
  logic [bcra_pkg::CFG_W-1:0]     ev_idx;
  logic                           ev_valid;
  logic [bcra_pkg::LEN_W-1:0]     count;

  logic [bcra_pkg::CFG_W-1:0]     vb;
  logic [bcra_pkg::LEN_W-1:0]     total;
  logic                           in_store;
  logic [7:0]                     cur_byte;
  logic [2:0]                     bit_sel;
  logic [7:0]                     set_mask;
  logic [7:0]                     wr_byte;
  logic                           more;
  logic                           rd_en;
  logic                           wr_en;
  logic [bcra_pkg::ADDR_W-1:0]    rd_addr;
  logic [bcra_pkg::ADDR_W-1:0]    wr_addr;
  logic [bcra_pkg::IDX_W-1:0]     start;
  bcra_pkg::byte_scan_t           scan;

  always_comb begin
    vb = (32'(bytes_in_use) > bcra_pkg::MAP_BYTES) ?
         bcra_pkg::CFG_W'(bcra_pkg::MAP_BYTES) : bytes_in_use;
    total    = {vb, 3'b000};
    in_store = (32'(req.bit_addr[8:3]) < bcra_pkg::MAP_BYTES);
    cur_byte = rd_vld ? rd_data : 8'h00;
    bit_sel  = req.bit_addr[2:0];
    set_mask = 8'h01 << bit_sel;
    wr_byte  = req.bit_value ? (cur_byte | set_mask) : (cur_byte & ~set_mask);
    more     = (ptr < vb);
    scan     = bcra_pkg::scan_byte(cur_byte, count, req.run_length);
    start    = bcra_pkg::IDX_W'({ev_idx, 3'b000}) + bcra_pkg::IDX_W'(scan.pos) +
               bcra_pkg::IDX_W'(1) - req.run_length[bcra_pkg::IDX_W-1:0];
    rd_en    = cmd.rd_req || (cmd.scan_step && more);
    rd_addr  = cmd.scan_step ? bcra_pkg::ADDR_W'(ptr) : bcra_pkg::ADDR_W'(req.bit_addr[8:3]);
    wr_addr  = bcra_pkg::ADDR_W'(req.bit_addr[8:3]);
    wr_en    = cmd.wr_bit && in_store;

    status.len_bad   = (req.run_length == '0) || (req.run_length > total);
    status.hit       = ev_valid && scan.hit;
    status.exhausted = !ev_valid && !more;
  end

  // bitmap memory, registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
      rd_vld  <= vld[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_byte;
    end
  end

  // an entry not yet written since reset, or since a clear-all within the bytes in use, reads as free
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (cmd.clr_all) begin
      for (int i = 0; i < bcra_pkg::MAP_BYTES; i++) begin
        if (i < 32'(vb)) begin
          vld[i] <= 1'b0;
        end
      end
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_in_use <= bcra_pkg::CFG_RESET;
    end else if (cfg_we) begin
      bytes_in_use <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else if (cmd.scan_init) begin
      ev_valid <= 1'b0;
    end else if (cmd.scan_step) begin
      ev_valid <= more;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= in_data;
    end
    if (cmd.scan_init) begin
      ptr   <= '0;
      count <= '0;
    end else if (cmd.scan_step) begin
      if (more) begin
        ptr    <= ptr + 1'b1;
        ev_idx <= ptr;
      end
      if (ev_valid) begin
        count <= scan.count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res <= '0;
    end else if (cmd.test_cap) begin
      res.bit_state <= in_store && cur_byte[bit_sel];
    end else if (cmd.scan_step && status.hit) begin
      res.found     <= 1'b1;
      res.run_start <= start;
    end
  end

endmodule

>>> sv/bcra_chk.sv
// port-level checks for the bitmap run allocator, attached by bind
// depends on bcra_pkg and bitmap_contiguous_run_allocator_unit
module bcra_chk (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input bcra_pkg::res_t out_data
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one request in flight: busy right after acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted without going busy");

  // a result without a found run carries no start
  a_start_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.found |-> out_data.run_start == '0)
    else $error("run start set without found");

  // scan and test results never mix
  a_scan_test_apart: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.found |-> !out_data.bit_state)
    else $error("found and bit state both set");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind bitmap_contiguous_run_allocator_unit bcra_chk u_bcra_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

>>> sim/bcra_checker.sv
// checker for the bitmap run allocator: follows the bitmap and bytes_in_use from
// accepted requests and register writes, and compares every result in order
// depends on bcra_pkg; instantiated beside the block by tb_top
module bcra_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  bcra_pkg::req_t             in_data,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  bcra_pkg::res_t             out_data,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [bcra_pkg::CFG_W-1:0] cfg_data,
  output int                         fail_count,
  output int                         pending
);

  logic [7:0]                 alloc_map [bcra_pkg::MAP_BYTES];
  logic [bcra_pkg::CFG_W-1:0] bytes_in_use;
  bcra_pkg::res_t             expected_results [$];
  int                         errs = 0;

  function automatic int unsigned live_bytes();
    return (bytes_in_use > bcra_pkg::MAP_BYTES) ? bcra_pkg::MAP_BYTES : bytes_in_use;
  endfunction

  // first-fit search, bit write, bit test or clear-all on the tracked bitmap
  task automatic allocate_step(input bcra_pkg::req_t r, output bcra_pkg::res_t res);
    int unsigned total;
    int unsigned run;
    int unsigned n;
    int unsigned b;
    res   = '0;
    total = live_bytes() * 8;
    b     = r.bit_addr >> 3;
    case (r.req_type)
      bcra_pkg::REQ_SCAN: begin
        run = 0;
        if (r.run_length != 0 && r.run_length <= total) begin
          for (n = 0; n < total && !res.found; n++) begin
            if (alloc_map[n >> 3][n % 8]) begin
              run = 0;
            end else begin
              run++;
              if (run == r.run_length) begin
                res.found     = 1'b1;
                res.run_start = bcra_pkg::IDX_W'(n + 1 - run);
              end
            end
          end
        end
      end
      bcra_pkg::REQ_WRITE: begin
        if (b < bcra_pkg::MAP_BYTES) alloc_map[b][r.bit_addr[2:0]] = r.bit_value;
      end
      bcra_pkg::REQ_TEST: begin
        if (b < bcra_pkg::MAP_BYTES) res.bit_state = alloc_map[b][r.bit_addr[2:0]];
      end
      default: begin
        for (n = 0; n < live_bytes(); n++) alloc_map[n] = 8'h00;
      end
    endcase
  endtask

  always @(posedge clk) begin
    bcra_pkg::res_t want;
    bcra_pkg::res_t pred;
    if (rst) begin
      for (int i = 0; i < bcra_pkg::MAP_BYTES; i++) alloc_map[i] = 8'h00;
      bytes_in_use = bcra_pkg::CFG_RESET;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) bytes_in_use = cfg_data;
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding");
          errs++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, out_data.found);
            errs++;
          end
          if (out_data.run_start !== want.run_start) begin
            $error("run_start: expected %0d, actual %0d", want.run_start, out_data.run_start);
            errs++;
          end
          if (out_data.bit_state !== want.bit_state) begin
            $error("bit_state: expected %0d, actual %0d", want.bit_state, out_data.bit_state);
            errs++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        allocate_step(in_data, pred);
        expected_results.push_back(pred);
      end
    end
    pending    <= expected_results.size();
    fail_count <= errs;
  end

endmodule

>>> sim/tb_top.sv
// testbench top for the bitmap run allocator: clock, reset, request and register
// stimulus with random idling, watchdog and verdict
// depends on bcra_pkg, bcra_checker and bitmap_contiguous_run_allocator_unit
module tb_top;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = bcra_pkg::MAP_BYTES + 16;

  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       in_valid  = 1'b0;
  bcra_pkg::req_t             in_data   = '0;
  logic                       out_stall = 1'b0;
  logic                       cfg_valid = 1'b0;
  logic [bcra_pkg::CFG_W-1:0] cfg_data  = '0;
  logic                       in_stall;
  logic                       out_valid;
  bcra_pkg::res_t             out_data;
  logic                       cfg_ready;
  int                         fail_count;
  int                         pending;
  int                         idle_cycles = 0;
  bit                         quiet = 1'b0;
  int                         span_bits = bcra_pkg::MAP_BYTES * 8;

  bitmap_contiguous_run_allocator_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  bcra_checker alloc_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= !rst && !quiet && ($urandom_range(99) < 27);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic bcra_pkg::req_t make_req(input bcra_pkg::req_kind_t kind,
                                              input int unsigned idx,
                                              input bit val, input int unsigned len);
    bcra_pkg::req_t r;
    r.req_type   = kind;
    r.bit_addr   = bcra_pkg::IDX_W'(idx);
    r.bit_value  = val;
    r.run_length = bcra_pkg::LEN_W'(len);
    return r;
  endfunction

  // mostly inside the bits in use, sometimes anywhere in the store
  function automatic int unsigned pick_index();
    int unsigned span;
    span = (span_bits == 0) ? 8 : span_bits;
    if ($urandom_range(99) < 85) return $urandom_range(span - 1);
    return $urandom_range(511);
  endfunction

  task automatic push_request(input bcra_pkg::req_t r);
    while (!quiet && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [bcra_pkg::CFG_W-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    span_bits = ((v > bcra_pkg::MAP_BYTES) ? bcra_pkg::MAP_BYTES : v) * 8;
  endtask

  task automatic random_phase(input int count);
    int          sent;
    int          choice;
    int unsigned base;
    int unsigned span;
    int unsigned len;
    int          k;
    bit          val;
    sent = 0;
    span = (span_bits == 0) ? 8 : span_bits;
    while (sent < count) begin
      choice = $urandom_range(99);
      if (choice < 20) begin
        // mark or free a contiguous block, as an allocation would
        k    = $urandom_range(1, 16);
        base = $urandom_range(span - 1);
        val  = ($urandom_range(99) < 75);
        for (int i = 0; i < k && sent < count; i++) begin
          push_request(make_req(bcra_pkg::REQ_WRITE, (base + i) % span, val,
                                $urandom_range(1023)));
          sent++;
        end
      end else if (choice < 45) begin
        push_request(make_req(bcra_pkg::REQ_WRITE, pick_index(), $urandom_range(1),
                              $urandom_range(1023)));
        sent++;
      end else if (choice < 75) begin
        choice = $urandom_range(99);
        if (choice < 55) len = $urandom_range(1, 12);
        else if (choice < 75) len = $urandom_range(1, span_bits + 2);
        else if (choice < 80) len = 0;
        else if (choice < 85) len = 1023;
        else len = $urandom_range(1023);
        push_request(make_req(bcra_pkg::REQ_SCAN, $urandom_range(511), $urandom_range(1),
                              len));
        sent++;
      end else if (choice < 97) begin
        push_request(make_req(bcra_pkg::REQ_TEST, pick_index(), $urandom_range(1),
                              $urandom_range(1023)));
        sent++;
      end else begin
        push_request(make_req(bcra_pkg::REQ_CLEAR, $urandom_range(511), $urandom_range(1),
                              $urandom_range(1023)));
        sent++;
      end
      if ($urandom_range(199) == 0) drain();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty map at reset size, runs at and past the store size, edge bits
    push_request(make_req(bcra_pkg::REQ_TEST, 0, 0, 0));
    push_request(make_req(bcra_pkg::REQ_SCAN, 0, 0, 1));
    push_request(make_req(bcra_pkg::REQ_SCAN, 0, 0, 512));
    push_request(make_req(bcra_pkg::REQ_SCAN, 0, 0, 513));
    push_request(make_req(bcra_pkg::REQ_SCAN, 0, 0, 0));
    push_request(make_req(bcra_pkg::REQ_SCAN, 511, 1, 1023));
    push_request(make_req(bcra_pkg::REQ_WRITE, 0, 1, 0));
    push_request(make_req(bcra_pkg::REQ_WRITE, 511, 1, 0));
    push_request(make_req(bcra_pkg::REQ_TEST, 511, 0, 0));
    push_request(make_req(bcra_pkg::REQ_TEST, 0, 0, 0));
    push_request(make_req(bcra_pkg::REQ_SCAN, 0, 0, 510));
    push_request(make_req(bcra_pkg::REQ_SCAN, 0, 0, 511));
    for (int i = 8; i < 16; i++) push_request(make_req(bcra_pkg::REQ_WRITE, i, 1, 0));
    push_request(make_req(bcra_pkg::REQ_SCAN, 0, 0, 8));
    push_request(make_req(bcra_pkg::REQ_WRITE, 0, 0, 0));
    push_request(make_req(bcra_pkg::REQ_CLEAR, 0, 0, 0));
    push_request(make_req(bcra_pkg::REQ_TEST, 511, 0, 0));

    // no bytes in use: scans miss, clear leaves stored bits alone
    write_cfg(7'd0);
    push_request(make_req(bcra_pkg::REQ_WRITE, 3, 1, 0));
    push_request(make_req(bcra_pkg::REQ_SCAN, 0, 0, 1));
    push_request(make_req(bcra_pkg::REQ_CLEAR, 0, 0, 0));
    push_request(make_req(bcra_pkg::REQ_TEST, 3, 0, 0));
    random_phase(60);

    // register above the store acts as the whole store
    write_cfg(7'd127);
    push_request(make_req(bcra_pkg::REQ_CLEAR, 0, 0, 0));
    push_request(make_req(bcra_pkg::REQ_SCAN, 0, 0, 512));
    random_phase(90);

    write_cfg(7'd1);
    random_phase(120);

    write_cfg(7'd8);
    quiet <= 1'b1;
    random_phase(120);
    drain();
    quiet <= 1'b0;

    write_cfg(bcra_pkg::CFG_W'($urandom_range(2, 63)));
    random_phase(120);

    write_cfg(7'd64);
    random_phase(120);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
